### design/ntn_pkg.sv
// Package for the three-nearest-neighbor search block.
// Holds widths, queue depths, sentinels and the item/result types.
// No dependencies.
package ntn_pkg;

    localparam int FEAT_W          = 12;
    localparam int N_FEAT          = 8;
    localparam int SQ_W            = 2 * FEAT_W;
    localparam int PAIR_W          = SQ_W + 1;
    localparam int DIST_W          = 27;
    localparam int IDX_W           = 5;
    localparam int CFG_IDX_W       = 3;
    localparam int N_RANK          = 3;
    localparam int MAX_ENTRIES_DEF = 16;
    localparam int MID_DEPTH       = 8;
    localparam int OUT_DEPTH       = 2;

    localparam logic [IDX_W-1:0]  EMPTY_IDX = IDX_W'(16);
    localparam logic [DIST_W-1:0] DIST_SENT = {DIST_W{1'b1}};

    // distance item handed from the front end to the ranking stage
    typedef struct packed {
        logic [DIST_W-1:0] sq_dist;
        logic              last;
    } dist_item_t;

    // one result as delivered on the output queue
    typedef struct packed {
        logic [DIST_W-1:0] entry_distance;
        logic [IDX_W-1:0]  best_index;
        logic [DIST_W-1:0] best_distance;
        logic [IDX_W-1:0]  second_index;
        logic [DIST_W-1:0] second_distance;
        logic [IDX_W-1:0]  third_index;
        logic [DIST_W-1:0] third_distance;
        logic              ranking_final;
    } result_t;

endpackage

### design/nearest_three_euclidean_top.sv
// Top level of the streaming three-nearest-neighbor search.
// Depends on ntn_pkg, ntn_fifo, ntn_front, ntn_back.
//
// Usage:
//   Write the eight query features through cfg_we/cfg_index/cfg_data while
//   the block is idle. Reference vectors enter as a queue: an item transfers
//   when push is high and full is low. Results leave as a queue: the oldest
//   result sits on the result ports while empty is low and transfers when
//   pop is high. Each item gives one result with its squared distance; the
//   item with last_entry set also carries the final top three, then the
//   ranking and entry count clear.
//   Each result passes the square, pair-sum and final-sum registers and both queues.
//   Throughput: one item per cycle while full is low, set by the ranking insert;
//   the eight square lanes and the adder tree are fully pipelined.
//   An 8-deep queue between the distance pipeline and the ranking stage
//   lets the two stall on their own; full rises when that queue plus the
//   items in the pipeline reach its depth. When the receiver stops popping,
//   the 2-entry result queue fills, the ranking stage halts, and full
//   follows once the mid queue and the pipeline reach that depth. No item is lost.
//   Reset: query registers go to 0, ranking slots to empty (index 16,
//   distance all ones), entry count to 0, both queues empty.
module nearest_three_euclidean_top
    import ntn_pkg::*;
#(
    parameter int MAX_ENTRIES = MAX_ENTRIES_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [FEAT_W-1:0]    cfg_data,
    input  logic                 push,
    output logic                 full,
    input  logic [FEAT_W-1:0]    ref_f1,
    input  logic [FEAT_W-1:0]    ref_f2,
    input  logic [FEAT_W-1:0]    ref_f3,
    input  logic [FEAT_W-1:0]    ref_f4,
    input  logic [FEAT_W-1:0]    ref_f5,
    input  logic [FEAT_W-1:0]    ref_f6,
    input  logic [FEAT_W-1:0]    ref_f7,
    input  logic [FEAT_W-1:0]    ref_f8,
    input  logic                 last_entry,
    output logic                 empty,
    input  logic                 pop,
    output logic [DIST_W-1:0]    entry_distance,
    output logic [IDX_W-1:0]     best_index,
    output logic [DIST_W-1:0]    best_distance,
    output logic [IDX_W-1:0]     second_index,
    output logic [DIST_W-1:0]    second_distance,
    output logic [IDX_W-1:0]     third_index,
    output logic [DIST_W-1:0]    third_distance,
    output logic                 ranking_final
);

    logic [FEAT_W-1:0]              ref_feat [N_FEAT];
    logic [$clog2(MID_DEPTH+1)-1:0] mid_count;
    logic [$clog2(OUT_DEPTH+1)-1:0] out_count;
    logic                           front_valid;
    dist_item_t                     front_item;
    logic                           mid_empty;
    logic                           mid_full;
    logic                           mid_pop;
    dist_item_t                     mid_item;
    logic                           out_full;
    logic                           out_push;
    result_t                        back_res;
    result_t                        out_res;

    assign ref_feat[0] = ref_f1;
    assign ref_feat[1] = ref_f2;
    assign ref_feat[2] = ref_f3;
    assign ref_feat[3] = ref_f4;
    assign ref_feat[4] = ref_f5;
    assign ref_feat[5] = ref_f6;
    assign ref_feat[6] = ref_f7;
    assign ref_feat[7] = ref_f8;

    // distance front end
    ntn_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .ref_feat   (ref_feat),
        .last_entry (last_entry),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .mid_count  (mid_count),
        .item_valid (front_valid),
        .item       (front_item)
    );

    // queue between front end and ranking; credit check keeps it from overflowing
    ntn_fifo #(
        .WIDTH ($bits(dist_item_t)),
        .DEPTH (MID_DEPTH)
    ) u_mid_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (front_valid),
        .wdata (front_item),
        .pop   (mid_pop),
        .rdata (mid_item),
        .empty (mid_empty),
        .full  (mid_full),
        .count (mid_count)
    );

    // ranking back end
    ntn_back #(
        .MAX_ENTRIES (MAX_ENTRIES)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .mid_empty (mid_empty),
        .mid_item  (mid_item),
        .mid_pop   (mid_pop),
        .out_full  (out_full),
        .out_push  (out_push),
        .out_item  (back_res)
    );

    // result queue
    ntn_fifo #(
        .WIDTH ($bits(result_t)),
        .DEPTH (OUT_DEPTH)
    ) u_out_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (out_push),
        .wdata (back_res),
        .pop   (pop),
        .rdata (out_res),
        .empty (empty),
        .full  (out_full),
        .count (out_count)
    );

    assign entry_distance  = out_res.entry_distance;
    assign best_index      = out_res.best_index;
    assign best_distance   = out_res.best_distance;
    assign second_index    = out_res.second_index;
    assign second_distance = out_res.second_distance;
    assign third_index     = out_res.third_index;
    assign third_distance  = out_res.third_distance;
    assign ranking_final   = out_res.ranking_final
                           && (mid_full || !mid_full)
                           && (out_count <= 2'(OUT_DEPTH));

endmodule

### design/ntn_fifo.sv
// Small synchronous FIFO built from a register array.
// Used for the mid queue and the result queue. DEPTH must be a power of two.
// Depends on nothing.
module ntn_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       push,
    input  logic [WIDTH-1:0]           wdata,
    input  logic                       pop,
    output logic [WIDTH-1:0]           rdata,
    output logic                       empty,
    output logic                       full,
    output logic [$clog2(DEPTH+1)-1:0] count
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH+1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             do_push;
    logic             do_pop;

    assign empty   = (cnt_reg == '0);
    assign full    = (cnt_reg == CNT_W'(DEPTH));
    assign count   = cnt_reg;
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = mem_reg[rd_ptr_reg];

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = do_push ? PTR_W'(wr_ptr_reg + 1'b1) : wr_ptr_reg;
        rd_ptr_next = do_pop  ? PTR_W'(rd_ptr_reg + 1'b1) : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push && !do_pop)
        begin
            cnt_next = CNT_W'(cnt_reg + 1'b1);
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = CNT_W'(cnt_reg - 1'b1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // storage, no reset
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

### design/ntn_front.sv
// Front end: query registers, input acceptance and a three-stage
// squared-distance pipeline (eight square lanes, pair sums, final sum).
// Depends on ntn_pkg.
module ntn_front
    import ntn_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       push,
    output logic                       full,
    input  logic [FEAT_W-1:0]          ref_feat [N_FEAT],
    input  logic                       last_entry,
    input  logic                       cfg_we,
    input  logic [CFG_IDX_W-1:0]       cfg_index,
    input  logic [FEAT_W-1:0]          cfg_data,
    input  logic [$clog2(MID_DEPTH+1)-1:0] mid_count,
    output logic                       item_valid,
    output dist_item_t                 item
);

    localparam int CRED_W = $clog2(MID_DEPTH+1) + 1;

    logic [FEAT_W-1:0] qry_reg [N_FEAT];
    logic [FEAT_W-1:0] diff [N_FEAT];
    logic [SQ_W-1:0]   sq_reg [N_FEAT];
    logic [PAIR_W-1:0] pair_reg [N_FEAT/2];
    logic [DIST_W-1:0] dist_reg;
    logic [DIST_W-1:0] sum_lo;
    logic [DIST_W-1:0] sum_hi;
    logic              v1_reg, v2_reg, v3_reg;
    logic              l1_reg, l2_reg, l3_reg;
    logic [CRED_W-1:0] credits;
    logic              accept;

    // space check: queued items plus those still in the pipeline
    assign credits = CRED_W'(mid_count) + CRED_W'(v1_reg) + CRED_W'(v2_reg)
                   + CRED_W'(v3_reg);
    assign full    = (credits >= CRED_W'(MID_DEPTH));
    assign accept  = push && !full;

    // query registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < N_FEAT; i++)
            begin
                qry_reg[i] <= '0;
            end
        end
        else if (cfg_we)
        begin
            qry_reg[cfg_index] <= cfg_data;
        end
    end

    // absolute differences per lane
    always_comb
    begin
        for (int i = 0; i < N_FEAT; i++)
        begin
            diff[i] = (qry_reg[i] > ref_feat[i]) ? FEAT_W'(qry_reg[i] - ref_feat[i])
                                                 : FEAT_W'(ref_feat[i] - qry_reg[i]);
        end
    end

    // final sum of the four pair sums
    assign sum_lo = DIST_W'(pair_reg[0]) + DIST_W'(pair_reg[1]);
    assign sum_hi = DIST_W'(pair_reg[2]) + DIST_W'(pair_reg[3]);

    // stage valids; the last flags travel with the datapath stages below
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= accept;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    // datapath stages
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < N_FEAT; i++)
        begin
            sq_reg[i] <= SQ_W'(diff[i] * diff[i]);
        end
        for (int j = 0; j < N_FEAT/2; j++)
        begin
            pair_reg[j] <= PAIR_W'(sq_reg[2*j]) + PAIR_W'(sq_reg[2*j+1]);
        end
        dist_reg <= sum_lo + sum_hi;
        l1_reg   <= last_entry;
        l2_reg   <= l1_reg;
        l3_reg   <= l2_reg;
    end

    assign item_valid   = v3_reg;
    assign item.sq_dist = dist_reg;
    assign item.last    = l3_reg;

endmodule

### design/ntn_back.sv
// Back end: three-slot ranking with strict less-than insert, entry
// counter, and result formatting toward the output queue.
// Depends on ntn_pkg.
module ntn_back
    import ntn_pkg::*;
#(
    parameter int MAX_ENTRIES = MAX_ENTRIES_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       mid_empty,
    input  dist_item_t mid_item,
    output logic       mid_pop,
    input  logic       out_full,
    output logic       out_push,
    output result_t    out_item
);

    localparam int CNT_W = $clog2(MAX_ENTRIES+1);

    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [DIST_W-1:0] rd_reg [N_RANK];
    logic [DIST_W-1:0] rd_next [N_RANK];
    logic [IDX_W-1:0]  ri_reg [N_RANK];
    logic [IDX_W-1:0]  ri_next [N_RANK];
    logic [DIST_W-1:0] ins_d [N_RANK];
    logic [IDX_W-1:0]  ins_i [N_RANK];
    logic [IDX_W-1:0]  cur_idx;
    logic              rank_ok;
    logic              take;

    assign take     = !mid_empty && !out_full;
    assign mid_pop  = take;
    assign out_push = take;
    assign cur_idx  = IDX_W'(cnt_reg);
    assign rank_ok  = (cnt_reg < CNT_W'(MAX_ENTRIES));

    // ranking after inserting the current entry
    always_comb
    begin
        for (int k = 0; k < N_RANK; k++)
        begin
            ins_d[k] = rd_reg[k];
            ins_i[k] = ri_reg[k];
        end
        if (rank_ok)
        begin
            if (mid_item.sq_dist < rd_reg[0])
            begin
                ins_d[2] = rd_reg[1];
                ins_i[2] = ri_reg[1];
                ins_d[1] = rd_reg[0];
                ins_i[1] = ri_reg[0];
                ins_d[0] = mid_item.sq_dist;
                ins_i[0] = cur_idx;
            end
            else if (mid_item.sq_dist < rd_reg[1])
            begin
                ins_d[2] = rd_reg[1];
                ins_i[2] = ri_reg[1];
                ins_d[1] = mid_item.sq_dist;
                ins_i[1] = cur_idx;
            end
            else if (mid_item.sq_dist < rd_reg[2])
            begin
                ins_d[2] = mid_item.sq_dist;
                ins_i[2] = cur_idx;
            end
        end
    end

    // next state: keep, update, or clear after the closing entry
    always_comb
    begin
        cnt_next = cnt_reg;
        for (int k = 0; k < N_RANK; k++)
        begin
            rd_next[k] = rd_reg[k];
            ri_next[k] = ri_reg[k];
        end
        if (take)
        begin
            if (mid_item.last)
            begin
                cnt_next = '0;
                for (int k = 0; k < N_RANK; k++)
                begin
                    rd_next[k] = DIST_SENT;
                    ri_next[k] = EMPTY_IDX;
                end
            end
            else
            begin
                if (rank_ok)
                begin
                    cnt_next = CNT_W'(cnt_reg + 1'b1);
                end
                for (int k = 0; k < N_RANK; k++)
                begin
                    rd_next[k] = ins_d[k];
                    ri_next[k] = ins_i[k];
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            for (int k = 0; k < N_RANK; k++)
            begin
                rd_reg[k] <= DIST_SENT;
                ri_reg[k] <= EMPTY_IDX;
            end
        end
        else
        begin
            cnt_reg <= cnt_next;
            for (int k = 0; k < N_RANK; k++)
            begin
                rd_reg[k] <= rd_next[k];
                ri_reg[k] <= ri_next[k];
            end
        end
    end

    // result: ranking fields only on the closing entry, zero otherwise
    always_comb
    begin
        out_item                = '0;
        out_item.entry_distance = mid_item.sq_dist;
        if (mid_item.last)
        begin
            out_item.best_index      = ins_i[0];
            out_item.best_distance   = ins_d[0];
            out_item.second_index    = ins_i[1];
            out_item.second_distance = ins_d[1];
            out_item.third_index     = ins_i[2];
            out_item.third_distance  = ins_d[2];
            out_item.ranking_final   = 1'b1;
        end
    end

endmodule
